/* design/crst_pkg.sv */
// Package with request and result types, state type and constants of the receive span tracker.
`timescale 1ns / 1ps

package crst_pkg;

  // Ring geometry, fixed by the 8-bit span offset and 9-bit position fields.
  localparam logic [8:0] RING_SIZE = 9'd256;
  localparam logic [8:0] HALF_RING = 9'd128;

  // Event kind codes. The spare code is handled as an idle line.
  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_HALF  = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Result status codes.
  localparam logic STATUS_SPAN     = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [8:0] position;
    logic [1:0] event_kind;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  span_offset;
    logic [8:0]  span_length;
    logic [8:0]  total_length;
    logic [1:0]  kind_echo;
    logic        opens_event;
    logic        closes_event;
    logic        run_end;
    logic [31:0] overflow_count;
    logic [31:0] event_count;
    logic [31:0] byte_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  consumer_offset;
    logic        expect_full;
    logic [31:0] overflows;
    logic [31:0] events;
    logic [31:0] bytes_total;
  } tracker_state_t;

  // Everything the span calculation hands back for one request.
  typedef struct packed {
    logic           has_first;
    logic           has_second;
    out_item_t      first;
    out_item_t      second;
    tracker_state_t state_nxt;
  } calc_res_t;

endpackage

/* design/crst_span_calc.sv */
// Combinational span and boundary check for one receive request.
`timescale 1ns / 1ps

module crst_span_calc (
  input  crst_pkg::in_item_t       item,
  input  crst_pkg::tracker_state_t state,
  output crst_pkg::calc_res_t      res
);

  logic [8:0]  pos;
  logic [1:0]  kind;
  logic [8:0]  start;
  logic        wrapped;
  logic [8:0]  len;
  logic [8:0]  head_len;
  logic [8:0]  required;
  logic [8:0]  expected;
  logic        bad_boundary;
  logic [7:0]  offset_nxt;
  logic [31:0] overflows_nxt;
  logic [31:0] events_nxt;
  logic [31:0] bytes_nxt;

  always_comb begin
    pos = (item.position > crst_pkg::RING_SIZE) ? crst_pkg::RING_SIZE : item.position;
    // Kind three is treated as idle.
    kind = (item.event_kind == crst_pkg::KIND_SPARE) ? crst_pkg::KIND_IDLE : item.event_kind;
    start = {1'b0, state.consumer_offset};
    wrapped = pos < start;
    head_len = crst_pkg::RING_SIZE - start;
    len = wrapped ? (head_len + pos) : (pos - start);
    required = (kind == crst_pkg::KIND_HALF) ? crst_pkg::HALF_RING : crst_pkg::RING_SIZE;
    expected = state.expect_full ? crst_pkg::RING_SIZE : crst_pkg::HALF_RING;
    bad_boundary = (kind != crst_pkg::KIND_IDLE) &&
                   ((pos != required) || (pos != expected) || (len == 9'd0) ||
                    (len > crst_pkg::HALF_RING));
    offset_nxt = (pos == crst_pkg::RING_SIZE) ? 8'd0 : pos[7:0];
    overflows_nxt = state.overflows + 32'd1;
    events_nxt = state.events + 32'd1;
    bytes_nxt = state.bytes_total + {23'd0, len};

    res = '0;
    res.state_nxt = state;

    if (bad_boundary) begin
      res.has_first = 1'b1;
      res.state_nxt.overflows = overflows_nxt;
      res.state_nxt.consumer_offset = offset_nxt;
      res.state_nxt.expect_full = (pos >= crst_pkg::HALF_RING) &&
                                  (pos != crst_pkg::RING_SIZE);
      res.first.status = crst_pkg::STATUS_OVERFLOW;
      res.first.kind_echo = kind;
      res.first.run_end = 1'b1;
      res.first.overflow_count = overflows_nxt;
      res.first.event_count = state.events;
      res.first.byte_count = state.bytes_total;
    end else if (len != 9'd0) begin
      res.has_first = 1'b1;
      res.has_second = wrapped && (pos != 9'd0);
      res.state_nxt.consumer_offset = offset_nxt;
      if (kind == crst_pkg::KIND_HALF) begin
        res.state_nxt.expect_full = 1'b1;
      end else if (kind == crst_pkg::KIND_FULL) begin
        res.state_nxt.expect_full = 1'b0;
      end
      res.state_nxt.events = events_nxt;
      res.state_nxt.bytes_total = bytes_nxt;

      res.first.status = crst_pkg::STATUS_SPAN;
      res.first.span_offset = state.consumer_offset;
      res.first.span_length = wrapped ? head_len : len;
      res.first.total_length = len;
      res.first.kind_echo = kind;
      res.first.opens_event = 1'b1;
      res.first.closes_event = !res.has_second;
      res.first.run_end = !res.has_second;
      res.first.overflow_count = state.overflows;
      res.first.event_count = events_nxt;
      res.first.byte_count = bytes_nxt;

      res.second = res.first;
      res.second.span_offset = 8'd0;
      res.second.span_length = pos;
      res.second.opens_event = 1'b0;
      res.second.closes_event = 1'b1;
      res.second.run_end = 1'b1;
    end
  end

endmodule

/* design/crst_out_buf.sv */
// Two-slot result buffer: the result register plus a holding slot for a wrap's second span.
`timescale 1ns / 1ps

module crst_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  crst_pkg::calc_res_t   res,
  output logic                  push_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crst_pkg::out_item_t   out_data
);

  logic                head_valid_r;
  logic                head_valid_nxt;
  crst_pkg::out_item_t head_r;
  crst_pkg::out_item_t head_nxt;
  logic                tail_valid_r;
  logic                tail_valid_nxt;
  crst_pkg::out_item_t tail_r;
  crst_pkg::out_item_t tail_nxt;
  logic                pop;

  assign pop       = head_valid_r && out_ready;
  assign push_ok   = !tail_valid_r && (!head_valid_r || out_ready);
  assign out_valid = head_valid_r;
  assign out_data  = head_r;

  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt = head_r;
    tail_valid_nxt = tail_valid_r;
    tail_nxt = tail_r;
    if (pop) begin
      head_valid_nxt = tail_valid_r;
      head_nxt = tail_r;
      tail_valid_nxt = 1'b0;
    end
    // push is only raised when push_ok holds, so the head slot is free here.
    if (push && res.has_first) begin
      head_valid_nxt = 1'b1;
      head_nxt = res.first;
      tail_valid_nxt = res.has_second;
      tail_nxt = res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      tail_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      tail_valid_r <= tail_valid_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

/* design/circular_rx_span_tracker.sv */
// Top level of the circular receive span tracker.
// A request is registered in the input register, its first result in the result register.
// Throughput: one request per cycle while out_ready is high and each request yields at most
// one result; a wrapping request yields two results through the single result port.
// Reset (rst_n, synchronous, active low) clears the consumer offset, boundary expectation,
// all three counters and every valid flag.
`timescale 1ns / 1ps

module circular_rx_span_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  crst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output crst_pkg::out_item_t out_data
);

  // The input register works as a skid stage: a request is taken even while a finished
  // result is still waiting at the output, and is held here until the result buffer has
  // room for everything it may produce.
  logic                     req_valid_r;
  logic                     req_valid_nxt;
  crst_pkg::in_item_t       req_r;
  crst_pkg::in_item_t       req_nxt;

  // Tracker state: consumer offset, which boundary comes next, and the running counters.
  crst_pkg::tracker_state_t state_r;
  crst_pkg::tracker_state_t state_nxt;

  crst_pkg::calc_res_t      calc_res;
  logic                     push_ok;
  logic                     advance;

  // The held request is evaluated against the current state in one pass of logic.
  crst_span_calc u_calc (
    .item  (req_r),
    .state (state_r),
    .res   (calc_res)
  );

  // A request leaves the input register only when the buffer can take both possible spans.
  assign advance  = req_valid_r && push_ok;
  assign in_ready = !req_valid_r || push_ok;

  always_comb begin
    req_valid_nxt = req_valid_r;
    req_nxt = req_r;
    state_nxt = state_r;
    if (advance) begin
      req_valid_nxt = 1'b0;
      // Idle requests with no new bytes leave the state as it is; the calculation
      // already reflects that in its next-state value.
      state_nxt = calc_res.state_nxt;
    end
    if (in_valid && in_ready) begin
      req_valid_nxt = 1'b1;
      req_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      state_r <= '0;
    end else begin
      req_valid_r <= req_valid_nxt;
      state_r <= state_nxt;
    end
    req_r <= req_nxt;
  end

  // Result register with a second slot for the tail span of a wrapping request.
  crst_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .res       (calc_res),
    .push_ok   (push_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
